>>> src/tgq_pkg.sv
// ----------------------------------------------------------------------------
// tgq_pkg - shared types and constants for the team grouped queue
// Item layouts, request and status codes, and the per-cell control word.
// ----------------------------------------------------------------------------
package tgq_pkg;

  localparam int QUEUE_DEPTH = 64;
  localparam int TEAM_W      = 10;
  localparam int VALUE_W     = 32;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    REQ_ENQ = 2'd0,
    REQ_DEQ = 2'd1,
    REQ_CLR = 2'd2
  } req_e;

  typedef enum logic [2:0] {
    STS_ENQUEUED = 3'd0,
    STS_DEQUEUED = 3'd1,
    STS_EMPTY    = 3'd2,
    STS_FULL     = 3'd3,
    STS_CLEARED  = 3'd4
  } status_e;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_e;

  typedef struct packed {
    logic [1:0]                req_type;
    logic [TEAM_W-1:0]         team_id;
    logic signed [VALUE_W-1:0] item_value;
  } in_t;

  typedef struct packed {
    logic [2:0]                status;
    logic signed [VALUE_W-1:0] head_value;
    logic [TEAM_W-1:0]         head_team;
  } out_t;

  typedef struct packed {
    logic [TEAM_W-1:0]         team;
    logic signed [VALUE_W-1:0] value;
  } slot_t;

  // control word handed to each cell
  typedef struct packed {
    logic cmp_en;
    logic clr;
    logic load;
    logic from_left;
    logic from_right;
  } cell_ctl_t;

endpackage

>>> src/team_grouped_queue.sv
// ----------------------------------------------------------------------------
// team_grouped_queue - ordered queue that keeps entries of a team together
// Row of slot cells driven by a small request sequencer.
// ----------------------------------------------------------------------------
// Usage:
//   Requests arrive on in_req and are taken at a clock edge where start is
//   high and busy is low. Each request gives exactly one item on out_rsp,
//   marked by out_valid for a single cycle; the receiver cannot stall it.
// Timing:
//   The edge that takes a request also has every cell compare its team
//   with the request. In the following cycle busy is high, the sequencer
//   turns the registered match flags into the insert point and the whole
//   row shifts or loads at the end of that cycle. out_valid is high in the
//   cycle after that. A new request is not taken while busy is high, so the
//   compare stage of the cell row and the shift stage never overlap.
// Behaviour:
//   Enqueue lands directly behind the last entry of the same team, else at
//   the tail; a full queue drops it (status full). Dequeue pops the head.
//   Clear empties the row at once. Unused request codes change nothing.
// Reset:
//   Synchronous active-low rst_n empties the queue and idles the sequencer.
// ----------------------------------------------------------------------------
module team_grouped_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  tgq_pkg::in_t  in_req,
  output logic          out_valid,
  output tgq_pkg::out_t out_rsp
);
  import tgq_pkg::*;

  cell_ctl_t [QUEUE_DEPTH-1:0] cell_ctl;
  slot_t     [QUEUE_DEPTH-1:0] slots;
  logic      [QUEUE_DEPTH-1:0] valid_vec;
  logic      [QUEUE_DEPTH-1:0] match_vec;
  slot_t                       new_slot;

  tgq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_req    (in_req),
    .valid_vec (valid_vec),
    .match_vec (match_vec),
    .head_slot (slots[0]),
    .cell_ctl  (cell_ctl),
    .new_slot  (new_slot),
    .out_valid (out_valid),
    .out_rsp   (out_rsp)
  );

  // slot 0 is the head; entries move towards the tail on insert and
  // towards the head on dequeue
  for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
    slot_t left_slot, right_slot;
    logic  left_valid, right_valid;

    if (g == 0) begin : g_head
      assign left_slot  = new_slot;
      assign left_valid = 1'b0;
    end else begin : g_mid_l
      assign left_slot  = slots[g-1];
      assign left_valid = valid_vec[g-1];
    end

    if (g == QUEUE_DEPTH - 1) begin : g_tail
      assign right_slot  = '0;
      assign right_valid = 1'b0;
    end else begin : g_mid_r
      assign right_slot  = slots[g+1];
      assign right_valid = valid_vec[g+1];
    end

    tgq_cell u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .ctl         (cell_ctl[g]),
      .cmp_team    (in_req.team_id),
      .new_slot    (new_slot),
      .left_slot   (left_slot),
      .left_valid  (left_valid),
      .right_slot  (right_slot),
      .right_valid (right_valid),
      .slot        (slots[g]),
      .valid       (valid_vec[g]),
      .match       (match_vec[g])
    );
  end

endmodule

>>> src/tgq_cell.sv
// ----------------------------------------------------------------------------
// tgq_cell - one queue slot
// Holds one entry, compares its team on request, loads, clears or shifts left or right.
// ----------------------------------------------------------------------------
module tgq_cell (
  input  logic              clk,
  input  logic              rst_n,
  input  tgq_pkg::cell_ctl_t ctl,
  input  logic [tgq_pkg::TEAM_W-1:0] cmp_team,
  input  tgq_pkg::slot_t    new_slot,
  input  tgq_pkg::slot_t    left_slot,
  input  logic              left_valid,
  input  tgq_pkg::slot_t    right_slot,
  input  logic              right_valid,
  output tgq_pkg::slot_t    slot,
  output logic              valid,
  output logic              match
);
  import tgq_pkg::*;

  slot_t slot_r, slot_nxt;
  logic  valid_r, valid_nxt;
  logic  match_r;

  always_comb begin
    slot_nxt  = slot_r;
    valid_nxt = valid_r;
    if (ctl.clr) begin
      valid_nxt = 1'b0;
    end else if (ctl.load) begin
      slot_nxt  = new_slot;
      valid_nxt = 1'b1;
    end else if (ctl.from_left) begin
      slot_nxt  = left_slot;
      valid_nxt = left_valid;
    end else if (ctl.from_right) begin
      slot_nxt  = right_slot;
      valid_nxt = right_valid;
    end
  end

  always_ff @(posedge clk) begin
    slot_r <= slot_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      match_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      if (ctl.cmp_en) begin
        match_r <= valid_r && (slot_r.team == cmp_team);
      end
    end
  end

  assign slot  = slot_r;
  assign valid = valid_r;
  assign match = match_r;

endmodule

>>> src/tgq_ctrl.sv
// ----------------------------------------------------------------------------
// tgq_ctrl - request sequencer for the team grouped queue
// Accepts requests, works out the insert point and drives the cell row.
// ----------------------------------------------------------------------------
module tgq_ctrl (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  tgq_pkg::in_t                       in_req,
  input  logic [tgq_pkg::QUEUE_DEPTH-1:0]    valid_vec,
  input  logic [tgq_pkg::QUEUE_DEPTH-1:0]    match_vec,
  input  tgq_pkg::slot_t                     head_slot,
  output tgq_pkg::cell_ctl_t [tgq_pkg::QUEUE_DEPTH-1:0] cell_ctl,
  output tgq_pkg::slot_t                     new_slot,
  output logic                               out_valid,
  output tgq_pkg::out_t                      out_rsp
);
  import tgq_pkg::*;

  state_e           state_r, state_nxt;
  in_t              req_r;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_t             out_r, out_nxt;
  logic             accept;
  logic             full;
  logic [QUEUE_DEPTH-1:0] m_ge;     // some match at this index or above
  logic [QUEUE_DEPTH-1:0] at_ge;    // index at or past the insert point
  logic [QUEUE_DEPTH-1:0] load_vec;

  for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_sfx
    assign m_ge[g]  = |match_vec[QUEUE_DEPTH-1:g];
    assign at_ge[g] = !m_ge[g] && (m_ge[0] || !valid_vec[g]);
  end

  assign accept   = start && (state_r == ST_IDLE);
  assign full     = (count_r == CNT_W'(QUEUE_DEPTH));
  assign new_slot = '{team: req_r.team_id, value: req_r.item_value};

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    out_valid_nxt = 1'b0;
    out_nxt       = '0;
    load_vec      = '0;
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      cell_ctl[i]        = '0;
      cell_ctl[i].cmp_en = accept;
    end
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_nxt     = ST_IDLE;
        out_valid_nxt = 1'b1;
        case (req_r.req_type)
          REQ_ENQ: begin
            if (full) begin
              out_nxt.status = STS_FULL;
            end else begin
              out_nxt.status = STS_ENQUEUED;
              count_nxt      = count_r + CNT_W'(1);
              for (int i = 0; i < QUEUE_DEPTH; i++) begin
                if (i == 0) begin
                  load_vec[i] = at_ge[i];
                end else begin
                  load_vec[i]           = at_ge[i] && !at_ge[i-1];
                  cell_ctl[i].from_left = at_ge[i] && at_ge[i-1];
                end
                cell_ctl[i].load = load_vec[i];
              end
            end
          end
          REQ_DEQ: begin
            if (count_r == '0) begin
              out_nxt.status = STS_EMPTY;
            end else begin
              out_nxt.status     = STS_DEQUEUED;
              out_nxt.head_value = head_slot.value;
              out_nxt.head_team  = head_slot.team;
              count_nxt          = count_r - CNT_W'(1);
              for (int i = 0; i < QUEUE_DEPTH; i++) begin
                cell_ctl[i].from_right = 1'b1;
              end
            end
          end
          REQ_CLR: begin
            out_nxt.status = STS_CLEARED;
            count_nxt      = '0;
            for (int i = 0; i < QUEUE_DEPTH; i++) begin
              cell_ctl[i].clr = 1'b1;
            end
          end
          default: begin
            out_nxt.status = STS_EMPTY;
          end
        endcase
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_r <= in_req;
    end
    out_r <= out_nxt;
  end

  assign busy      = (state_r == ST_EXEC);
  assign out_valid = out_valid_r;
  assign out_rsp   = out_r;

`ifndef SYNTHESIS
  a_count_matches_valid: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(valid_vec) == int'(count_r))
    else $error("live cell count differs from entry count");

  a_valid_packed: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_vec & (valid_vec + QUEUE_DEPTH'(1))) == '0)
    else $error("live cells not packed from the head");

  a_single_load: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(load_vec))
    else $error("more than one cell loading");

  a_result_after_exec: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(state_r == ST_EXEC))
    else $error("result strobe without an executed request");

  a_enq_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EXEC && req_r.req_type == REQ_ENQ && !full)
      |=> count_r == $past(count_r) + CNT_W'(1))
    else $error("enqueue did not add an entry");
`endif

endmodule
